FILE: rtl/chdd_pkg.sv
// ----------------------------------------------------------------------------
// chdd_pkg
// Shared types and constant tables for the charlieplexed display driver.
// ----------------------------------------------------------------------------
package chdd_pkg;

   localparam int unsigned SCAN_COUNT   = 18;
   localparam int unsigned PATTERN_W    = 18;
   localparam int unsigned SCAN_W       = 5;
   localparam int unsigned SEG_W        = 7;
   localparam int unsigned DIGIT_W      = 4;
   localparam int unsigned PIN_COUNT    = 5;

   localparam logic [7:0]  MAX_SHOWN    = 8'd188;
   localparam logic [7:0]  HUNDRED      = 8'd100;
   localparam logic [7:0]  TEN          = 8'd10;
   localparam logic [7:0]  LAST_BLANK   = 8'd9;
   localparam logic [7:0]  TENS_RECIP   = 8'd205;   // ~2048/10
   localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd10;
   localparam logic [SCAN_W-1:0]  LAST_POS    = 5'd17;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // pin drive codes
   localparam logic [1:0] PF = 2'd0;   // float
   localparam logic [1:0] PH = 2'd1;   // drive high
   localparam logic [1:0] PL = 2'd2;   // drive low

   typedef logic [PIN_COUNT-1:0][1:0] pins_type;   // [4] = pin a ... [0] = pin e

   typedef struct packed {
      pins_type          pins;
      logic [SCAN_W-1:0] pos;
   } drive_type;

   localparam logic [SEG_W-1:0] SEG_TABLE [11] = '{
      7'd126, 7'd48, 7'd109, 7'd121, 7'd51, 7'd91, 7'd95, 7'd112, 7'd127, 7'd123, 7'd0
   };

   // pin pair per scan position, pins a..e
   localparam pins_type DRIVE_TABLE [SCAN_COUNT] = '{
      {PF, PH, PF, PF, PL}, {PF, PF, PH, PF, PL}, {PL, PF, PF, PF, PH},
      {PL, PF, PF, PH, PF}, {PH, PF, PF, PL, PF}, {PL, PF, PH, PF, PF},
      {PH, PF, PL, PF, PF}, {PL, PH, PF, PF, PF}, {PH, PL, PF, PF, PF},
      {PF, PF, PF, PL, PH}, {PF, PF, PL, PF, PH}, {PF, PL, PF, PF, PH},
      {PF, PL, PF, PH, PF}, {PF, PF, PL, PH, PF}, {PF, PL, PH, PF, PF},
      {PF, PH, PL, PF, PF}, {PF, PH, PF, PL, PF}, {PF, PF, PH, PL, PF}
   };

endpackage

FILE: rtl/charlieplex_segment_display_driver.sv
// ----------------------------------------------------------------------------
// charlieplex_segment_display_driver
// Loads a segment pattern and scans it out over five charlieplexed pins.
// ----------------------------------------------------------------------------
// A tick transaction's pin drive reaches the rsp_ ports through the input
// register, then the result register. Loads give no result.
// Throughput: one transaction per cycle; the only stall comes from rsp_stall
// holding a finished result in the result register.
// Reset: synchronous, active high; pattern cleared (display dark), scan at 0.
module charlieplex_segment_display_driver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_value,
   input  logic       req_indicator_a,
   input  logic       req_indicator_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_pin_a,
   output logic [1:0] rsp_pin_b,
   output logic [1:0] rsp_pin_c,
   output logic [1:0] rsp_pin_d,
   output logic [1:0] rsp_pin_e,
   output logic [4:0] rsp_scan_position
);

   logic                            s1_valid_ff;
   logic                            s1_command_ff;
   logic [7:0]                      s1_value_ff;
   logic                            s1_ind_a_ff;
   logic                            s1_ind_b_ff;
   logic [chdd_pkg::PATTERN_W-1:0]  pattern_ff;
   logic [chdd_pkg::PATTERN_W-1:0]  pattern_in;
   logic [chdd_pkg::PATTERN_W-1:0]  new_pattern;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   chdd_pkg::drive_type             out_ff;
   chdd_pkg::drive_type             drive;
   logic                            out_free;
   logic                            s1_move;
   logic                            tick_move;
   logic                            req_take;

   chdd_pattern u_pattern (
      .value       (s1_value_ff),
      .indicator_a (s1_ind_a_ff),
      .indicator_b (s1_ind_b_ff),
      .pattern     (new_pattern)
   );

   chdd_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (tick_move),
      .pattern (pattern_ff),
      .drive   (drive)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      // loads retire without a result, so only ticks wait on the result side
      s1_move   = s1_valid_ff && ((s1_command_ff == chdd_pkg::CMD_LOAD) || out_free);
      tick_move = s1_move && (s1_command_ff == chdd_pkg::CMD_TICK);
      req_stall = s1_valid_ff && !s1_move;
      req_take  = req_valid && !req_stall;
      pattern_in = pattern_ff;
      if (s1_move && (s1_command_ff == chdd_pkg::CMD_LOAD)) begin
         pattern_in = new_pattern;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (tick_move) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pattern_ff   <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
         pattern_ff   <= pattern_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_value_ff   <= req_value;
         s1_ind_a_ff   <= req_indicator_a;
         s1_ind_b_ff   <= req_indicator_b;
      end
      if (tick_move) begin
         out_ff <= drive;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pin_a         = out_ff.pins[4];
   assign rsp_pin_b         = out_ff.pins[3];
   assign rsp_pin_c         = out_ff.pins[2];
   assign rsp_pin_d         = out_ff.pins[1];
   assign rsp_pin_e         = out_ff.pins[0];
   assign rsp_scan_position = out_ff.pos;

   a_rise_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(tick_move))
      else $error("result appeared without a tick transaction");

   a_dark_floats: assert property (@(posedge clock) disable iff (reset)
      tick_move && (pattern_ff == '0) |=>
         (rsp_pin_a == chdd_pkg::PF) && (rsp_pin_b == chdd_pkg::PF) &&
         (rsp_pin_c == chdd_pkg::PF) && (rsp_pin_d == chdd_pkg::PF) &&
         (rsp_pin_e == chdd_pkg::PF))
      else $error("dark pattern drove a pin");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      tick_move |-> out_free)
      else $error("held result overwritten");

   a_load_keeps_pattern: assert property (@(posedge clock) disable iff (reset)
      !(s1_move && (s1_command_ff == chdd_pkg::CMD_LOAD)) |=> $stable(pattern_ff))
      else $error("pattern changed without a load");

endmodule

FILE: rtl/chdd_pattern.sv
// ----------------------------------------------------------------------------
// chdd_pattern
// Converts a display value and two indicator flags into the segment pattern.
// ----------------------------------------------------------------------------
module chdd_pattern (
   input  logic [7:0]                      value,
   input  logic                            indicator_a,
   input  logic                            indicator_b,
   output logic [chdd_pkg::PATTERN_W-1:0]  pattern
);

   logic                          shown;
   logic                          hundred;
   logic [7:0]                    rem;
   logic [15:0]                   tens_prod;
   logic [chdd_pkg::DIGIT_W-1:0]  tens;
   logic [7:0]                    units_full;
   logic [chdd_pkg::DIGIT_W-1:0]  tens_idx;
   logic [chdd_pkg::SEG_W-1:0]    tens_seg;
   logic [chdd_pkg::SEG_W-1:0]    units_seg;

   always_comb begin
      shown      = (value <= chdd_pkg::MAX_SHOWN);
      hundred    = (value >= chdd_pkg::HUNDRED);
      rem        = hundred ? (value - chdd_pkg::HUNDRED) : value;
      // rem < 100 whenever shown, so the reciprocal gives an exact quotient
      tens_prod  = {8'd0, rem} * {8'd0, chdd_pkg::TENS_RECIP};
      tens       = tens_prod[14:11];
      units_full = rem - ({4'd0, tens} * chdd_pkg::TEN);
      tens_idx   = (value > chdd_pkg::LAST_BLANK) ? tens : chdd_pkg::BLANK_DIGIT;
      tens_seg   = chdd_pkg::SEG_TABLE[tens_idx];
      units_seg  = chdd_pkg::SEG_TABLE[units_full[3:0]];
      pattern    = {18{1'b0}};
      if (shown) begin
         pattern[17:16] = {2{hundred}};
         pattern[15:9]  = tens_seg;
         pattern[8:2]   = units_seg;
      end
      pattern[1] = indicator_a;
      pattern[0] = indicator_b;
   end

endmodule

FILE: rtl/chdd_scan.sv
// ----------------------------------------------------------------------------
// chdd_scan
// Scan position counter and pin drive lookup for one tick.
// ----------------------------------------------------------------------------
module chdd_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [chdd_pkg::PATTERN_W-1:0]  pattern,
   output chdd_pkg::drive_type             drive
);

   logic [chdd_pkg::SCAN_W-1:0] scan_index_ff;
   logic [chdd_pkg::SCAN_W-1:0] scan_index_in;
   logic [chdd_pkg::SCAN_W-1:0] pos;
   logic                        lit;

   always_comb begin
      pos = (scan_index_ff > chdd_pkg::LAST_POS) ? '0 : scan_index_ff;
      lit = pattern[pos];
      drive.pos  = pos;
      drive.pins = lit ? chdd_pkg::DRIVE_TABLE[pos] : '0;
      scan_index_in = scan_index_ff;
      if (advance) begin
         scan_index_in = (pos == chdd_pkg::LAST_POS) ? '0 : pos + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= '0;
      end else begin
         scan_index_ff <= scan_index_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      scan_index_ff <= chdd_pkg::LAST_POS)
      else $error("scan index out of range");

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && (pos == chdd_pkg::LAST_POS) |=> scan_index_ff == '0)
      else $error("scan index failed to wrap");

endmodule

FILE: verif/chdd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chdd_checker
// Watches both channels of the charlieplexed display driver, keeps its own
// copy of the segment pattern and scan index, and compares every scan result
// against the drive predicted for it.
// ----------------------------------------------------------------------------
module chdd_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_value,
   input  logic       req_indicator_a,
   input  logic       req_indicator_b,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_pin_a,
   input  logic [1:0] rsp_pin_b,
   input  logic [1:0] rsp_pin_c,
   input  logic [1:0] rsp_pin_d,
   input  logic [1:0] rsp_pin_e,
   input  logic [4:0] rsp_scan_position,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [1:0]                  a;
      logic [1:0]                  b;
      logic [1:0]                  c;
      logic [1:0]                  d;
      logic [1:0]                  e;
      logic [chdd_pkg::SCAN_W-1:0] pos;
   } scan_drive_type;

   // segments a..g per digit (a in the MSB), last entry is the blank digit
   localparam logic [chdd_pkg::SEG_W-1:0] DIGIT_SEGS [11] = '{
      7'd126, 7'd48, 7'd109, 7'd121, 7'd51, 7'd91, 7'd95, 7'd112, 7'd127, 7'd123, 7'd0
   };

   localparam logic [1:0] F = chdd_pkg::PF;
   localparam logic [1:0] H = chdd_pkg::PH;
   localparam logic [1:0] L = chdd_pkg::PL;

   // lit pin pair per scan position, index 0 is pin a
   localparam logic [1:0] PAIR_DRIVE [chdd_pkg::SCAN_COUNT][chdd_pkg::PIN_COUNT] = '{
      '{F, H, F, F, L}, '{F, F, H, F, L}, '{L, F, F, F, H},
      '{L, F, F, H, F}, '{H, F, F, L, F}, '{L, F, H, F, F},
      '{H, F, L, F, F}, '{L, H, F, F, F}, '{H, L, F, F, F},
      '{F, F, F, L, H}, '{F, F, L, F, H}, '{F, L, F, F, H},
      '{F, L, F, H, F}, '{F, F, L, H, F}, '{F, L, H, F, F},
      '{F, H, L, F, F}, '{F, H, F, L, F}, '{F, F, H, L, F}
   };

   logic [chdd_pkg::PATTERN_W-1:0] pattern;
   logic [chdd_pkg::SCAN_W-1:0]    scan_idx;
   scan_drive_type                 drive_q [$];

   function automatic logic [chdd_pkg::PATTERN_W-1:0] encode_display(logic [7:0] n,
                                                                      logic ka, logic kb);
      logic [chdd_pkg::PATTERN_W-1:0] p;
      int                             num;
      int                             tens;
      p   = '0;
      num = n;
      if (n <= chdd_pkg::MAX_SHOWN) begin
         if (n >= chdd_pkg::HUNDRED) p[17:16] = 2'b11;
         // tens digit stays blank for single-digit values
         tens = (n > chdd_pkg::LAST_BLANK) ? (num % 100) / 10 : int'(chdd_pkg::BLANK_DIGIT);
         p[15:9] = DIGIT_SEGS[tens];
         p[8:2]  = DIGIT_SEGS[num % 10];
      end
      p[1] = ka;
      p[0] = kb;
      return p;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      scan_drive_type              got;
      scan_drive_type              want;
      logic [chdd_pkg::SCAN_W-1:0] pos;
      logic                        lit;
      if (reset) begin
         pattern    = '0;
         scan_idx   = '0;
         fail_count = 0;
         drive_q.delete();
      end else begin
         // result side first: a result never belongs to a transaction taken this edge
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pin_a, rsp_pin_b, rsp_pin_c, rsp_pin_d, rsp_pin_e, rsp_scan_position};
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual position %0d",
                        $time, got.pos);
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               check_field("pin_a", want.a, got.a);
               check_field("pin_b", want.b, got.b);
               check_field("pin_c", want.c, got.c);
               check_field("pin_d", want.d, got.d);
               check_field("pin_e", want.e, got.e);
               check_field("scan_position", want.pos, got.pos);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == chdd_pkg::CMD_LOAD) begin
               pattern = encode_display(req_value, req_indicator_a, req_indicator_b);
            end else begin
               pos = (scan_idx >= chdd_pkg::SCAN_COUNT) ? '0 : scan_idx;
               lit = pattern[pos];
               want.a   = lit ? PAIR_DRIVE[pos][0] : chdd_pkg::PF;
               want.b   = lit ? PAIR_DRIVE[pos][1] : chdd_pkg::PF;
               want.c   = lit ? PAIR_DRIVE[pos][2] : chdd_pkg::PF;
               want.d   = lit ? PAIR_DRIVE[pos][3] : chdd_pkg::PF;
               want.e   = lit ? PAIR_DRIVE[pos][4] : chdd_pkg::PF;
               want.pos = pos;
               drive_q.push_back(want);
               scan_idx = (pos == chdd_pkg::LAST_POS) ? '0 : pos + 5'd1;
            end
         end
      end
      pending = drive_q.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and scan transactions into the charlieplexed display driver
// under changing sender and receiver idling, including a long receiver
// hold-off, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 630;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_LIMIT  = 5000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_command;
   logic [7:0] req_value;
   logic       req_indicator_a;
   logic       req_indicator_b;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_pin_a;
   logic [1:0] rsp_pin_b;
   logic [1:0] rsp_pin_c;
   logic [1:0] rsp_pin_d;
   logic [1:0] rsp_pin_e;
   logic [4:0] rsp_scan_position;

   int   fail_count;
   int   pending;
   int   cycles;
   int   tx_idle_pct;
   int   rx_idle_pct;
   logic want_hold;
   logic hold_done;
   int   hold_left;

   charlieplex_segment_display_driver u_top (.*);

   chdd_checker u_check (.*);

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[charlieplex_segment_display_driver] ERROR");
         $finish;
      end
   end

   // receiver: random stall, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (want_hold && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic send_item(logic cmd, logic [7:0] val, logic ka, logic kb);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_value       <= val;
      req_indicator_a <= ka;
      req_indicator_b <= kb;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random();
      logic [7:0] edge_vals [10];
      logic [7:0] val;
      logic       cmd;
      edge_vals = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd109, 8'd110, 8'd188, 8'd189, 8'd255};
      cmd = ($urandom_range(99) < 30) ? chdd_pkg::CMD_LOAD : chdd_pkg::CMD_TICK;
      val = ($urandom_range(9) < 2) ? edge_vals[$urandom_range(9)] : 8'($urandom_range(255));
      send_item(cmd, val, 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int drain;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= chdd_pkg::CMD_TICK;
      req_value       <= '0;
      req_indicator_a <= 1'b0;
      req_indicator_b <= 1'b0;
      want_hold       <= 1'b0;
      tx_idle_pct      = 0;
      rx_idle_pct     <= 0;
      drain            = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // largest shown value with both lamps, then a full scan sweep
      send_item(chdd_pkg::CMD_LOAD, 8'd188, 1'b1, 1'b1);
      repeat (chdd_pkg::SCAN_COUNT) send_item(chdd_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
      // blanked digits keep the lamps
      send_item(chdd_pkg::CMD_LOAD, 8'd255, 1'b1, 1'b0);
      send_item(chdd_pkg::CMD_TICK, 8'd255, 1'b1, 1'b1);
      // single digit, tens blank
      send_item(chdd_pkg::CMD_LOAD, 8'd9, 1'b0, 1'b1);
      send_item(chdd_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
      // leading one with a zero tens digit
      send_item(chdd_pkg::CMD_LOAD, 8'd105, 1'b0, 1'b0);
      send_item(chdd_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 20;
               rx_idle_pct <= 84;
            end
            1: begin
               tx_idle_pct  = 84;
               rx_idle_pct <= 20;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_idle_pct <= 0;
               want_hold   <= 1'b1;
            end
         endcase
         repeat (PHASE_ITEMS) send_random();
      end
      req_valid <= 1'b0;

      while (pending != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[charlieplex_segment_display_driver] OK");
      end else begin
         $display("[charlieplex_segment_display_driver] ERROR");
      end
      $finish;
   end

endmodule
